>>> rtl/qbfc_pkg.sv
// ----------------------------------------------------------------------------
// qbfc_pkg
// Shared widths, operation codes and defaults of the quantile bin feature
// categorizer.
// ----------------------------------------------------------------------------
package qbfc_pkg;

   localparam int DEF_MAX_FEATURES = 256;
   localparam int DEF_SLOTS        = 4;

   localparam int OP_W      = 2;
   localparam int FEAT_W    = 8;
   localparam int SLOT_W    = 2;
   localparam int VALUE_W   = 32;
   localparam int COUNT_W   = 3;
   localparam int CAT_W     = 2;
   localparam int NUM_FEAT_W = 9;

   localparam logic [OP_W-1:0] OP_SET        = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE      = 2'd1;
   localparam logic [OP_W-1:0] OP_CATEGORIZE = 2'd2;

   // table access requests issued at the accept edge
   typedef struct packed {
      logic meta_we;
      logic slot_we;
      logic rd_en;
   } tbl_cmd_type;

endpackage

>>> rtl/qbfc_table.sv
// ----------------------------------------------------------------------------
// qbfc_table
// Feature table: a mode/count memory and a row-wide slot value memory, both
// with registered reads. Clears the mode/count memory after reset.
// ----------------------------------------------------------------------------
module qbfc_table #(
   parameter int MAX_FEATURES = qbfc_pkg::DEF_MAX_FEATURES,
   parameter int SLOTS        = qbfc_pkg::DEF_SLOTS
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  qbfc_pkg::tbl_cmd_type                         cmd_i,
   input  logic [qbfc_pkg::FEAT_W-1:0]                   feature_i,
   input  logic [qbfc_pkg::SLOT_W-1:0]                   slot_i,
   input  logic [qbfc_pkg::VALUE_W-1:0]                  value_i,
   input  logic                                          discrete_i,
   input  logic [qbfc_pkg::COUNT_W-1:0]                  count_i,
   output logic                                          clear_busy_o,
   output logic [SLOTS-1:0][qbfc_pkg::VALUE_W-1:0]       row_o,
   output logic                                          mode_o,
   output logic [$clog2(SLOTS+1)-1:0]                    count_o
);
   import qbfc_pkg::*;

   localparam int FW     = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int CW     = $clog2(SLOTS + 1);
   localparam int SW     = $clog2(SLOTS);
   localparam int SAT_W  = (CW > COUNT_W) ? CW : COUNT_W;
   localparam int META_W = CW + 1;

   logic [META_W-1:0]              meta_mem_ff [MAX_FEATURES];
   logic [SLOTS-1:0][VALUE_W-1:0]  slot_mem_ff [MAX_FEATURES];

   logic [SLOTS-1:0][VALUE_W-1:0]  row_rd_ff;
   logic [META_W-1:0]              meta_rd_ff;

   logic                           clr_busy_ff, clr_busy_in;
   logic [FW-1:0]                  clr_addr_ff, clr_addr_in;

   logic [FW-1:0]                  addr;
   logic [SW-1:0]                  slot_idx;
   logic [SAT_W-1:0]               cnt_ext;
   logic [SAT_W-1:0]               cnt_lim;
   logic [SAT_W-1:0]               cnt_sat;
   logic [META_W-1:0]              meta_new;

   assign addr     = FW'(feature_i);
   assign slot_idx = SW'(slot_i);

   // saturate: discrete to SLOTS, continuous to SLOTS-1
   assign cnt_ext  = SAT_W'(count_i);
   assign cnt_lim  = discrete_i ? SAT_W'(SLOTS) : SAT_W'(SLOTS - 1);
   assign cnt_sat  = (cnt_ext > cnt_lim) ? cnt_lim : cnt_ext;
   assign meta_new = {discrete_i, CW'(cnt_sat)};

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + FW'(1);
         if (clr_addr_ff == FW'(MAX_FEATURES - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         meta_mem_ff[clr_addr_ff] <= '0;
      end else if (cmd_i.meta_we) begin
         meta_mem_ff[addr] <= meta_new;
      end
      if (cmd_i.rd_en) begin
         meta_rd_ff <= meta_mem_ff[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.slot_we) begin
         slot_mem_ff[addr][slot_idx] <= value_i;
      end
      if (cmd_i.rd_en) begin
         row_rd_ff <= slot_mem_ff[addr];
      end
   end

   assign clear_busy_o = clr_busy_ff;
   assign row_o        = row_rd_ff;
   assign mode_o       = meta_rd_ff[META_W-1];
   assign count_o      = meta_rd_ff[CW-1:0];

endmodule

>>> rtl/qbfc_binner.sv
// ----------------------------------------------------------------------------
// qbfc_binner
// Compare stage and output register: matches the sample against the row
// read from the table and picks the bin or matched slot.
// ----------------------------------------------------------------------------
module qbfc_binner #(
   parameter int SLOTS = qbfc_pkg::DEF_SLOTS
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          load_i,
   input  logic [qbfc_pkg::FEAT_W-1:0]                   feature_i,
   input  logic [qbfc_pkg::VALUE_W-1:0]                  sample_i,
   input  logic                                          feature_ok_i,
   input  logic [SLOTS-1:0][qbfc_pkg::VALUE_W-1:0]       row_i,
   input  logic                                          mode_i,
   input  logic [$clog2(SLOTS+1)-1:0]                    count_i,
   output logic                                          ready_o,
   output logic                                          rsp_valid,
   input  logic                                          rsp_ready,
   output logic [qbfc_pkg::CAT_W-1:0]                    rsp_category,
   output logic [qbfc_pkg::FEAT_W-1:0]                   rsp_feature_echo
);
   import qbfc_pkg::*;

   localparam int CW = $clog2(SLOTS + 1);

   logic                 s1_valid_ff, s1_valid_in;
   logic [FEAT_W-1:0]    s1_feature_ff;
   logic [VALUE_W-1:0]   s1_sample_ff;
   logic                 s1_ok_ff;

   logic                 out_valid_ff, out_valid_in;
   logic [CAT_W-1:0]     out_category_ff;
   logic [FEAT_W-1:0]    out_feature_ff;

   logic                 s1_fire;
   logic [CW-1:0]        cat;
   logic                 hit;

   // advance the compare stage when the output register is free or draining
   assign s1_fire = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign ready_o = !s1_valid_ff || !out_valid_ff || rsp_ready;

   always_comb begin
      cat = '0;
      hit = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         if (!hit && (CW'(i) < count_i)) begin
            if (mode_i ? (row_i[i] == s1_sample_ff)
                       : ($signed(s1_sample_ff) < $signed(row_i[i]))) begin
               cat = CW'(i);
               hit = 1'b1;
            end
         end
      end
      if (!hit && !mode_i) begin
         cat = count_i;
      end
      if (!s1_ok_ff) begin
         cat = '0;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (load_i) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (load_i) begin
         s1_feature_ff <= feature_i;
         s1_sample_ff  <= sample_i;
         s1_ok_ff      <= feature_ok_i;
      end
      if (s1_fire) begin
         out_category_ff <= cat[CAT_W-1:0];
         out_feature_ff  <= s1_feature_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_category     = out_category_ff;
   assign rsp_feature_echo = out_feature_ff;

endmodule

>>> rtl/quantile_bin_feature_categorizer_unit.sv
// ----------------------------------------------------------------------------
// quantile_bin_feature_categorizer_unit
// Per-feature quantile bin / discrete match categorizer with a loadable
// feature table.
//
//   channel | direction | handshake                   | payload
//   req     | in        | req_valid / req_ready       | operation, feature, slot, value,
//           |           |                             | discrete, count
//   rsp     | out       | rsp_valid / rsp_ready       | category, feature_echo
//   csr     | in        | csr_write_enable            | feature limit
//
// One transaction per cycle while req_ready is high: the table is read at the accept edge, the
// compare runs in the next cycle and the result lands in the output register.
// After reset the mode/count memory is cleared one entry a cycle; req_ready stays
// low meanwhile, csr writes are taken. A stalled rsp holds the compare stage;
// apart from the clear, req_ready drops only when both the compare stage and the
// output register are full and rsp_ready is low.
// ----------------------------------------------------------------------------
module quantile_bin_feature_categorizer_unit #(
   parameter int MAX_FEATURES = qbfc_pkg::DEF_MAX_FEATURES,
   parameter int SLOTS        = qbfc_pkg::DEF_SLOTS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [qbfc_pkg::OP_W-1:0]            req_operation,
   input  logic [qbfc_pkg::FEAT_W-1:0]          req_feature_index,
   input  logic [qbfc_pkg::SLOT_W-1:0]          req_slot,
   input  logic signed [qbfc_pkg::VALUE_W-1:0]  req_value,
   input  logic                                 req_discrete,
   input  logic [qbfc_pkg::COUNT_W-1:0]         req_count,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [qbfc_pkg::CAT_W-1:0]           rsp_category,
   output logic [qbfc_pkg::FEAT_W-1:0]          rsp_feature_echo,
   input  logic                                 csr_write_enable,
   input  logic [qbfc_pkg::NUM_FEAT_W-1:0]      csr_write_data
);
   import qbfc_pkg::*;

   localparam int CW = $clog2(SLOTS + 1);

   logic [NUM_FEAT_W-1:0]          feat_limit_ff, feat_limit_in;
   logic                           accept;
   logic                           feature_ok;
   logic                           slot_ok;
   logic                           clear_busy;
   logic                           binner_ready;
   tbl_cmd_type                    cmd;
   logic [SLOTS-1:0][VALUE_W-1:0]  row;
   logic                           mode;
   logic [CW-1:0]                  count;

   assign feat_limit_in = csr_write_enable ? csr_write_data : feat_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         feat_limit_ff <= '0;
      end else begin
         feat_limit_ff <= feat_limit_in;
      end
   end

   assign req_ready  = !clear_busy && binner_ready;
   assign accept     = req_valid && req_ready;
   assign feature_ok = (32'(req_feature_index) < 32'(feat_limit_ff))
                    && (32'(req_feature_index) < 32'(MAX_FEATURES));
   assign slot_ok    = 32'(req_slot) < 32'(SLOTS);

   always_comb begin
      cmd = '0;
      if (accept) begin
         unique case (req_operation)
            OP_SET:        cmd.meta_we = feature_ok;
            OP_WRITE:      cmd.slot_we = feature_ok && slot_ok;
            OP_CATEGORIZE: cmd.rd_en   = 1'b1;
            default:       cmd         = '0;
         endcase
      end
   end

   qbfc_table #(
      .MAX_FEATURES (MAX_FEATURES),
      .SLOTS        (SLOTS)
   ) u_table (
      .clock        (clock),
      .reset        (reset),
      .cmd_i        (cmd),
      .feature_i    (req_feature_index),
      .slot_i       (req_slot),
      .value_i      (req_value),
      .discrete_i   (req_discrete),
      .count_i      (req_count),
      .clear_busy_o (clear_busy),
      .row_o        (row),
      .mode_o       (mode),
      .count_o      (count)
   );

   qbfc_binner #(
      .SLOTS            (SLOTS)
   ) u_binner (
      .clock            (clock),
      .reset            (reset),
      .load_i           (cmd.rd_en),
      .feature_i        (req_feature_index),
      .sample_i         (req_value),
      .feature_ok_i     (feature_ok),
      .row_i            (row),
      .mode_i           (mode),
      .count_i          (count),
      .ready_o          (binner_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_category     (rsp_category),
      .rsp_feature_echo (rsp_feature_echo)
   );

endmodule
